### src/ogt_pkg.sv
`default_nettype none
package ogt_pkg;

  // Default configuration of the datapath
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;

  // Datapath widths
  localparam int PERIOD_W = 24;
  localparam int TIME_W   = 32;
  localparam int ROT_W    = 34;  // rotation CORDIC, Q2.30 plus headroom
  localparam int VEC_W    = 36;  // vectoring CORDIC components
  localparam int ANG_W    = 34;  // vectoring angle accumulator, 2^32 per turn

  // Q30 constants and binary angles
  localparam logic signed [ROT_W-1:0] GAIN_INV_Q30 = 34'sd652032874;
  localparam logic signed [ROT_W-1:0] HALF_TURN    = 34'sd2147483648;
  localparam logic signed [ROT_W-1:0] QUARTER_TURN = 34'sd1073741824;

  // Reset values of the configuration registers
  localparam logic [PERIOD_W-1:0] ORBIT_PERIOD_RST = 24'd5400;
  localparam logic [PERIOD_W-1:0] EARTH_PERIOD_RST = 24'd86400;
  localparam logic signed [15:0]  INCL_RST         = 16'sd0;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ORBIT_PERIOD = 2'd0,
    REG_INCLINATION  = 2'd1,
    REG_EARTH_PERIOD = 2'd2,
    REG_NONE         = 2'd3
  } reg_index_t;

  // Arctangent of 2^-i in 2^32 units per turn
  function automatic logic signed [ROT_W-1:0] atan_of(input int i);
    logic signed [ROT_W-1:0] v;
    v = '0;
    case (i)
      0:  v = 34'sd536870912;
      1:  v = 34'sd316933406;
      2:  v = 34'sd167458907;
      3:  v = 34'sd85004756;
      4:  v = 34'sd42667331;
      5:  v = 34'sd21354465;
      6:  v = 34'sd10680862;
      7:  v = 34'sd5340245;
      8:  v = 34'sd2670163;
      9:  v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41721;
      15: v = 34'sd20860;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2607;
      19: v = 34'sd1303;
      20: v = 34'sd651;
      21: v = 34'sd325;
      22: v = 34'sd162;
      23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### src/ogt_phase.sv
`default_nettype none
module ogt_phase
  import ogt_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [TIME_W-1:0]   time_s,
  input  logic [PERIOD_W-1:0] period,
  output logic                out_valid,
  output logic [31:0]         phase
);

  localparam int NS = TIME_W + ANGLE_BITS;

  logic [NS:0]         vld;
  logic [PERIOD_W:0]   rem [0:NS];
  logic [TIME_W-1:0]   tsh [0:NS];
  logic [ANGLE_BITS-1:0] quo [0:NS];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign tsh[0] = time_s;
  assign quo[0] = '0;

  // One quotient bit per stage: first the remainder of time, then the fraction
  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [PERIOD_W:0] shifted;
    logic [PERIOD_W:0] diff;
    logic              take;

    if (k < TIME_W) begin : g_mod
      assign shifted = {rem[k][PERIOD_W-1:0], tsh[k][TIME_W-1]};
    end else begin : g_frac
      assign shifted = {rem[k][PERIOD_W-1:0], 1'b0};
    end

    assign take = shifted >= {1'b0, period};
    assign diff = shifted - {1'b0, period};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= take ? diff : shifted;
        tsh[k+1] <= {tsh[k][TIME_W-2:0], 1'b0};
        quo[k+1] <= {quo[k][ANGLE_BITS-2:0], take};
      end
    end
  end

  // Place the fraction in a 32 bit angle; a zero period gives phase zero
  assign out_valid = vld[NS];
  assign phase = (period == '0) ? '0 : {quo[NS], {(32 - ANGLE_BITS){1'b0}}};

endmodule
`default_nettype wire

### src/ogt_sincos.sv
`default_nettype none
module ogt_sincos
  import ogt_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [31:0]        angle,
  output logic               out_valid,
  output logic signed [15:0] cos_q,
  output logic signed [15:0] sin_q
);

  localparam int NS = CORDIC_STEPS + 2;

  logic [NS-1:0]           vld;
  logic signed [ROT_W-1:0] xs [0:CORDIC_STEPS];
  logic signed [ROT_W-1:0] ys [0:CORDIC_STEPS];
  logic signed [ROT_W-1:0] zs [0:CORDIC_STEPS];
  logic [CORDIC_STEPS:0]   ng;

  // Valid bits follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  // Fold the angle into a quarter turn around zero
  logic signed [ROT_W-1:0] z_in;
  logic signed [ROT_W-1:0] z_fold;
  logic                    neg_fold;

  always_comb begin
    z_in     = ROT_W'(signed'(angle));
    z_fold   = z_in;
    neg_fold = 1'b0;
    if (z_in > QUARTER_TURN) begin
      z_fold   = z_in - HALF_TURN;
      neg_fold = 1'b1;
    end else if (z_in < -QUARTER_TURN) begin
      z_fold   = z_in + HALF_TURN;
      neg_fold = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= GAIN_INV_Q30;
      ys[0] <= '0;
      zs[0] <= z_fold;
      ng[0] <= neg_fold;
    end
  end

  // Micro-rotations, one per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_of(i);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_of(i);
        end
        ng[i+1] <= ng[i];
      end
    end
  end

  // Undo the fold, round to Q1.15 and saturate
  function automatic logic signed [15:0] to_q15(input logic signed [ROT_W-1:0] v);
    logic signed [ROT_W-1:0] r;
    r = (v + ROT_W'(16384)) >>> 15;
    if (r > 32767) begin
      return 16'sh7fff;
    end else if (r < -32768) begin
      return 16'sh8000;
    end
    return r[15:0];
  endfunction

  logic signed [ROT_W-1:0] x_fin;
  logic signed [ROT_W-1:0] y_fin;

  assign x_fin = ng[CORDIC_STEPS] ? -xs[CORDIC_STEPS] : xs[CORDIC_STEPS];
  assign y_fin = ng[CORDIC_STEPS] ? -ys[CORDIC_STEPS] : ys[CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= to_q15(x_fin);
      sin_q <= to_q15(y_fin);
    end
  end

  assign out_valid = vld[NS-1];

endmodule
`default_nettype wire

### src/ogt_vector.sv
`default_nettype none
module ogt_vector
  import ogt_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int AUX_W        = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [VEC_W-1:0] xv,
  input  logic signed [VEC_W-1:0] yv,
  input  logic [AUX_W-1:0]        aux_in,
  output logic                    out_valid,
  output logic signed [ANG_W-1:0] ang,
  output logic signed [VEC_W-1:0] mag,
  output logic [AUX_W-1:0]        aux_out
);

  localparam int NS = CORDIC_STEPS + 1;

  logic [NS-1:0]           vld;
  logic signed [VEC_W-1:0] xs [0:CORDIC_STEPS];
  logic signed [VEC_W-1:0] ys [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] as [0:CORDIC_STEPS];
  logic [CORDIC_STEPS:0]   zf;
  logic [AUX_W-1:0]        ax [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  // Flag a zero vector, turn the left half plane by a half turn
  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (xv == '0) && (yv == '0);
      ax[0] <= aux_in;
      if (xv < 0) begin
        xs[0] <= -xv;
        ys[0] <= -yv;
        as[0] <= ANG_W'(HALF_TURN);
      end else begin
        xs[0] <= xv;
        ys[0] <= yv;
        as[0] <= '0;
      end
    end
  end

  // Drive y toward zero, one step per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          as[i+1] <= as[i] + ANG_W'(atan_of(i));
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          as[i+1] <= as[i] - ANG_W'(atan_of(i));
        end
        zf[i+1] <= zf[i];
        ax[i+1] <= ax[i];
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign ang       = zf[CORDIC_STEPS] ? '0 : as[CORDIC_STEPS];
  assign mag       = zf[CORDIC_STEPS] ? '0 : xs[CORDIC_STEPS];
  assign aux_out   = ax[CORDIC_STEPS];

endmodule
`default_nettype wire

### src/orbit_ground_track_core.sv
`default_nettype none
// Data pass through the bit-per-stage period dividers, a sine and cosine CORDIC
// and two vectoring CORDIC pipelines.
// Throughput: one time per cycle; a stalled output holds the whole pipeline.
// Reset clears all valid bits and loads the periods with 5400 s and 86400 s
// and the inclination with zero; no data path register is cleared.
module orbit_ground_track_core
  import ogt_pkg::*;
#(
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [TIME_W-1:0]   time_s,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  latitude,
  output logic signed [15:0]  longitude,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [PERIOD_W-1:0] cfg_data
);

  logic en;
  assign en        = out_ready | ~out_valid;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // Configuration registers
  logic [PERIOD_W-1:0] orbit_period_s;
  logic [PERIOD_W-1:0] earth_period_s;
  logic signed [15:0]  inclination_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      orbit_period_s    <= ORBIT_PERIOD_RST;
      earth_period_s    <= EARTH_PERIOD_RST;
      inclination_angle <= INCL_RST;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_ORBIT_PERIOD: orbit_period_s    <= cfg_data;
        REG_INCLINATION:  inclination_angle <= signed'(cfg_data[15:0]);
        REG_EARTH_PERIOD: earth_period_s    <= cfg_data;
        REG_NONE:         ;
        default:          ;
      endcase
    end
  end

  // Phases of orbit and Earth rotation
  logic        ph_valid;
  logic        ph_valid_e;
  logic [31:0] orbit_phase;
  logic [31:0] earth_phase;

  ogt_phase #(.ANGLE_BITS(ANGLE_BITS)) u_orbit_phase (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid & in_ready), .time_s(time_s),
    .period(orbit_period_s), .out_valid(ph_valid), .phase(orbit_phase)
  );

  ogt_phase #(.ANGLE_BITS(ANGLE_BITS)) u_earth_phase (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid & in_ready), .time_s(time_s),
    .period(earth_period_s), .out_valid(ph_valid_e), .phase(earth_phase)
  );

  // Sine and cosine of the three angles
  logic               sc_valid;
  logic               sc_valid_i;
  logic               sc_valid_e;
  logic signed [15:0] c1, s1, c2, s2, c3, s3;

  ogt_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_orbit_sc (
    .clk(clk), .rst(rst), .en(en), .in_valid(ph_valid), .angle(orbit_phase),
    .out_valid(sc_valid), .cos_q(c1), .sin_q(s1)
  );

  ogt_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_incl_sc (
    .clk(clk), .rst(rst), .en(en), .in_valid(ph_valid),
    .angle({inclination_angle, 16'h0000}),
    .out_valid(sc_valid_i), .cos_q(c2), .sin_q(s2)
  );

  ogt_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_earth_sc (
    .clk(clk), .rst(rst), .en(en), .in_valid(ph_valid_e), .angle(earth_phase),
    .out_valid(sc_valid_e), .cos_q(c3), .sin_q(s3)
  );

  // Orbit phase and inclination: products of Q15 factors on the unit vector
  logic               v1;
  logic signed [31:0] x2, y2, z1;
  logic signed [15:0] c3_d, s3_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= sc_valid & sc_valid_i & sc_valid_e;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2   <= c2 * s1;
      y2   <= s2 * s1;
      z1   <= {c1[15], c1, 15'h0000};
      c3_d <= c3;
      s3_d <= s3;
    end
  end

  // Earth rotation: four products
  logic               v2;
  logic signed [47:0] p1, p2, p3, p4;
  logic signed [31:0] y2_d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1    <= c3_d * x2;
      p2    <= s3_d * z1;
      p3    <= s3_d * x2;
      p4    <= c3_d * z1;
      y2_d2 <= y2;
    end
  end

  // Sum and scale back to Q30
  logic               v3;
  logic signed [48:0] dx, dz;
  logic signed [VEC_W-1:0] x3, z3;
  logic signed [31:0] y2_d3;

  assign dx = 49'(p1) - 49'(p2);
  assign dz = 49'(p3) + 49'(p4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x3    <= VEC_W'(signed'(dx[48:15]));
      z3    <= VEC_W'(signed'(dz[48:15]));
      y2_d3 <= y2_d2;
    end
  end

  // Longitude from the angle of (z, x)
  logic                    v4;
  logic signed [ANG_W-1:0] lon_ang;
  logic signed [VEC_W-1:0] lon_mag;
  logic [31:0]             y2_d4;

  ogt_vector #(.CORDIC_STEPS(CORDIC_STEPS), .AUX_W(32)) u_lon (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3), .xv(z3), .yv(x3),
    .aux_in(y2_d3), .out_valid(v4), .ang(lon_ang), .mag(lon_mag), .aux_out(y2_d4)
  );

  // Remove the CORDIC gain from the horizontal length
  logic                    v5;
  logic signed [66:0]      r_prod;
  logic signed [31:0]      y2_d5;
  logic [15:0]             lon16;
  logic signed [ANG_W-1:0] lon_rnd;

  assign lon_rnd = lon_ang + ANG_W'(32768);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_prod <= lon_mag * 31'(GAIN_INV_Q30);
      y2_d5  <= signed'(y2_d4);
      lon16  <= lon_rnd[31:16];
    end
  end

  // Latitude from the angle of (length, y)
  logic                    v6;
  logic signed [ANG_W-1:0] lat_ang;
  logic signed [VEC_W-1:0] lat_mag;
  logic [15:0]             lon16_d;
  logic signed [ANG_W-1:0] lat_rnd;

  ogt_vector #(.CORDIC_STEPS(CORDIC_STEPS), .AUX_W(16)) u_lat (
    .clk(clk), .rst(rst), .en(en), .in_valid(v5), .xv(VEC_W'(r_prod[65:30])),
    .yv(VEC_W'(y2_d5)), .aux_in(lon16), .out_valid(v6), .ang(lat_ang), .mag(lat_mag),
    .aux_out(lon16_d)
  );

  assign lat_rnd = lat_ang + ANG_W'(32768);

  // Output register; the length of the latitude run is not needed
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      latitude  <= signed'(lat_rnd[31:16]);
      longitude <= signed'(lon16_d);
    end
  end

  logic unused_bits;
  assign unused_bits = ^lat_mag;

endmodule
`default_nettype wire
